// File: rtl/core/lei_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lei_pkg
// shared widths, pipeline stage numbers and the per-stage sideband record
// for the element interpolator
// ----------------------------------------------------------------------------
package lei_pkg;

    localparam int ACC_W    = 52;      // horner accumulator, q.4
    localparam int XI_W     = 21;      // reference coordinate, q.16
    localparam int Q1_BITS  = 20;      // quotient bits of the coordinate divider
    localparam int Q2_BITS  = 32;      // quotient bits of the slope divider
    localparam int REM1_W   = 51;
    localparam int REM2_W   = 64;
    localparam int HORNER_LAT = 3;

    localparam logic [Q1_BITS-1:0] XI_LIMIT = Q1_BITS'(524288);

    // stage numbers, stage 0 is the input capture register
    localparam int ST_PREP = 1;
    localparam int ST_NORM = 2;
    localparam int ST_DIV1 = 3;
    localparam int ST_XI   = ST_DIV1 + Q1_BITS;
    localparam int ST_H2   = ST_XI + HORNER_LAT;
    localparam int ST_H3   = ST_H2 + HORNER_LAT;
    localparam int ST_FIN  = ST_H3 + HORNER_LAT + 1;
    localparam int ST_DIV2 = ST_FIN + 1;
    localparam int ST_OUT  = ST_DIV2 + Q2_BITS;

    typedef struct packed {
        logic                     bad;
        logic                     sat;
        logic [31:0]              d;
        logic signed [34:0]       m;
        logic                     mneg;
        logic                     ovf1;
        logic [REM1_W-1:0]        rem1;
        logic [Q1_BITS-1:0]       q1;
        logic signed [XI_W-1:0]   xi;
        logic signed [ACC_W-1:0]  p0;
        logic signed [ACC_W-1:0]  p1;
        logic signed [ACC_W-1:0]  p2;
        logic signed [ACC_W-1:0]  p3;
        logic signed [ACC_W-1:0]  p3x3;
        logic signed [ACC_W-1:0]  p2x2;
        logic signed [ACC_W-1:0]  du;
        logic [31:0]              value;
        logic                     dneg;
        logic                     ovf2;
        logic [REM2_W-1:0]        rem2;
        logic [Q2_BITS-1:0]       q2;
        logic [31:0]              slope;
    } lei_side_t;

endpackage
`default_nettype wire

// File: rtl/core/lagrange_element_interpolator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lagrange_element_interpolator
// value and slope of a 1d lagrange element of order 1 to 3 at one point
// ----------------------------------------------------------------------------
//  channel   signals                                         direction
//  request   req_valid req_stall eval_point left_bound       in
//            right_bound element_order weight_0..weight_3
//  result    res_valid res_stall value_out slope_out         out
//            bad_element saturated
//
//  one request per cycle unless a stalled result holds the pipeline
//  the pipeline holds the 20 step coordinate divider, three 3-stage horner
//  steps and the 32 step slope divider, one quotient bit per stage
//  reset clears the valid bits only, no clearing pass
//  a stalled result freezes the whole pipeline, req_stall follows it
// ----------------------------------------------------------------------------
module lagrange_element_interpolator (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_stall,
    input  wire logic signed [31:0] eval_point,
    input  wire logic signed [31:0] left_bound,
    input  wire logic signed [31:0] right_bound,
    input  wire logic [1:0]         element_order,
    input  wire logic signed [31:0] weight_0,
    input  wire logic signed [31:0] weight_1,
    input  wire logic signed [31:0] weight_2,
    input  wire logic signed [31:0] weight_3,
    output logic                    res_valid,
    input  wire logic               res_stall,
    output logic signed [31:0]      value_out,
    output logic signed [31:0]      slope_out,
    output logic                    bad_element,
    output logic                    saturated
);

    localparam int LAST = lei_pkg::ST_OUT;

    logic                     en;
    logic [LAST:0]            v_reg;
    logic [LAST:0]            v_next;
    logic signed [31:0]       x_reg, a_reg, b_reg;
    logic [1:0]               ord_reg;
    logic signed [31:0]       w0_reg, w1_reg, w2_reg, w3_reg;
    lei_pkg::lei_side_t       side_reg  [1:LAST];
    lei_pkg::lei_side_t       side_next [1:LAST];

    logic signed [lei_pkg::ACC_W-1:0] h1u_res, h1d_res, h2u_res, h2d_res, h3u_res;

    function automatic logic signed [lei_pkg::ACC_W-1:0] sx(input logic signed [31:0] v);
        sx = {{(lei_pkg::ACC_W-32){v[31]}}, v};
    endfunction

    assign en        = !(v_reg[LAST] && res_stall);
    assign req_stall = !en;

    always_comb
    begin
        v_next = {v_reg[LAST-1:0], req_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg   <= eval_point;
            a_reg   <= left_bound;
            b_reg   <= right_bound;
            ord_reg <= element_order;
            w0_reg  <= weight_0;
            w1_reg  <= weight_1;
            w2_reg  <= weight_2;
            w3_reg  <= weight_3;
            for (int s = 1; s <= LAST; s++)
            begin
                side_reg[s] <= side_next[s];
            end
        end
    end

    always_comb
    begin
        logic signed [32:0]               dd;
        logic signed [32:0]               xa;
        logic signed [lei_pkg::ACC_W-1:0] e0, e1, e2, e3;
        logic [34:0]                      mag;
        logic [51:0]                      t1;
        logic [lei_pkg::REM2_W-1:0]       t2;
        logic [lei_pkg::ACC_W-1:0]        ut;
        logic [47:0]                      rv;
        logic [lei_pkg::ACC_W-1:0]        dmag;
        logic [lei_pkg::Q1_BITS-1:0]      xm;
        logic                             clip;
        int                               bit_i;

        for (int s = 2; s <= LAST; s++)
        begin
            side_next[s] = side_reg[s-1];
        end

        // element geometry and polynomial coefficients
        side_next[1] = '0;
        dd = {b_reg[31], b_reg} - {a_reg[31], a_reg};
        xa = {x_reg[31], x_reg} - {a_reg[31], a_reg};
        side_next[1].bad = dd[32] || (dd == 33'sd0);
        side_next[1].d   = dd[31:0];
        side_next[1].m   = ({{2{xa[32]}}, xa} <<< 1) - {{2{dd[32]}}, dd};
        e0 = sx(w0_reg);
        e1 = sx(w1_reg);
        e2 = sx(w2_reg);
        e3 = sx(w3_reg);
        case (ord_reg)
            2'd2:
            begin
                side_next[1].p0 = e1 <<< 4;
                side_next[1].p1 = (e2 - e0) <<< 3;
                side_next[1].p2 = ((e0 + e2) <<< 3) - (e1 <<< 4);
                side_next[1].p3 = '0;
            end
            2'd3:
            begin
                side_next[1].p0 = ((e1 + e2) <<< 3) + e1 + e2 - e0 - e3;
                side_next[1].p1 = ((e2 - e1) <<< 5) - ((e2 - e1) <<< 2) - (e2 - e1)
                                  + e0 - e3;
                side_next[1].p2 = ((e0 - e1 - e2 + e3) <<< 3) + (e0 - e1 - e2 + e3);
                side_next[1].p3 = ((e3 - e0) <<< 3) + (e3 - e0)
                                  + ((e1 - e2) <<< 5) - ((e1 - e2) <<< 2) - (e1 - e2);
            end
            default:
            begin
                // order zero runs as linear
                side_next[1].p0 = (e0 + e1) <<< 3;
                side_next[1].p1 = (e1 - e0) <<< 3;
                side_next[1].p2 = '0;
                side_next[1].p3 = '0;
            end
        endcase

        // dividend for the coordinate, rounding half added up front
        side_next[lei_pkg::ST_NORM].mneg = side_reg[1].m[34];
        mag = side_reg[1].m[34] ? 35'(-side_reg[1].m) : 35'(side_reg[1].m);
        side_next[lei_pkg::ST_NORM].rem1 = lei_pkg::REM1_W'({mag[33:0], 16'd0})
                                           + lei_pkg::REM1_W'(side_reg[1].d[31:1]);
        side_next[lei_pkg::ST_NORM].ovf1 =
            {1'b0, side_next[lei_pkg::ST_NORM].rem1} >= {side_reg[1].d, 20'd0};
        side_next[lei_pkg::ST_NORM].q1   = '0;
        side_next[lei_pkg::ST_NORM].p3x3 = (side_reg[1].p3 <<< 1) + side_reg[1].p3;
        side_next[lei_pkg::ST_NORM].p2x2 = side_reg[1].p2 <<< 1;

        // restoring division, one quotient bit per stage
        for (int j = 0; j < lei_pkg::Q1_BITS; j++)
        begin
            bit_i = lei_pkg::Q1_BITS - 1 - j;
            t1 = 52'(side_reg[lei_pkg::ST_DIV1+j-1].d) << bit_i;
            if ({1'b0, side_reg[lei_pkg::ST_DIV1+j-1].rem1} >= t1)
            begin
                side_next[lei_pkg::ST_DIV1+j].rem1 =
                    side_reg[lei_pkg::ST_DIV1+j-1].rem1 - t1[lei_pkg::REM1_W-1:0];
                side_next[lei_pkg::ST_DIV1+j].q1[bit_i] = 1'b1;
            end
        end

        // clip the coordinate to +-8
        clip = side_reg[lei_pkg::ST_XI-1].ovf1
               || (side_reg[lei_pkg::ST_XI-1].q1 > lei_pkg::XI_LIMIT);
        xm = clip ? lei_pkg::XI_LIMIT : side_reg[lei_pkg::ST_XI-1].q1;
        side_next[lei_pkg::ST_XI].sat = clip;
        side_next[lei_pkg::ST_XI].xi  = side_reg[lei_pkg::ST_XI-1].mneg
                                        ? -$signed({1'b0, xm}) : $signed({1'b0, xm});

        // derivative leaves its horner step level with stage ST_H3
        side_next[lei_pkg::ST_H3+1].du = h2d_res;

        // value rounding and slope dividend
        ut = h3u_res + 52'd8 - {51'd0, h3u_res[51]};
        rv = ut[51:4];
        clip = (rv[47:31] != {17{1'b0}}) && (rv[47:31] != {17{1'b1}});
        side_next[lei_pkg::ST_FIN].value = clip ? (rv[47] ? 32'h8000_0000 : 32'h7fff_ffff)
                                                : rv[31:0];
        side_next[lei_pkg::ST_FIN].sat  = side_reg[lei_pkg::ST_FIN-1].sat || clip;
        side_next[lei_pkg::ST_FIN].dneg = side_reg[lei_pkg::ST_FIN-1].du[51];
        dmag = side_reg[lei_pkg::ST_FIN-1].du[51] ? 52'(-side_reg[lei_pkg::ST_FIN-1].du)
                                                  : 52'(side_reg[lei_pkg::ST_FIN-1].du);
        side_next[lei_pkg::ST_FIN].rem2 = {1'b0, dmag[49:0], 13'd0}
            + lei_pkg::REM2_W'(side_reg[lei_pkg::ST_FIN-1].d[31:1]);
        side_next[lei_pkg::ST_FIN].ovf2 =
            side_next[lei_pkg::ST_FIN].rem2 >= {side_reg[lei_pkg::ST_FIN-1].d, 32'd0};
        side_next[lei_pkg::ST_FIN].q2 = '0;

        for (int j = 0; j < lei_pkg::Q2_BITS; j++)
        begin
            bit_i = lei_pkg::Q2_BITS - 1 - j;
            t2 = lei_pkg::REM2_W'(side_reg[lei_pkg::ST_DIV2+j-1].d) << bit_i;
            if (side_reg[lei_pkg::ST_DIV2+j-1].rem2 >= t2)
            begin
                side_next[lei_pkg::ST_DIV2+j].rem2 =
                    side_reg[lei_pkg::ST_DIV2+j-1].rem2 - t2;
                side_next[lei_pkg::ST_DIV2+j].q2[bit_i] = 1'b1;
            end
        end

        // final stage overrides the last divider stage
        if (side_next[LAST].dneg)
        begin
            clip = side_next[LAST].ovf2
                   || (side_next[LAST].q2[31] && (side_next[LAST].q2[30:0] != 31'd0));
            side_next[LAST].slope = clip ? 32'h8000_0000 : (32'd0 - side_next[LAST].q2);
        end
        else
        begin
            clip = side_next[LAST].ovf2 || side_next[LAST].q2[31];
            side_next[LAST].slope = clip ? 32'h7fff_ffff : side_next[LAST].q2;
        end
        side_next[LAST].sat = side_next[LAST].sat || clip;
        if (side_next[LAST].bad)
        begin
            side_next[LAST].value = '0;
            side_next[LAST].slope = '0;
            side_next[LAST].sat   = 1'b0;
        end
    end

    lei_horner_step u_h1u (
        .clk  (clk),
        .en   (en),
        .acc  (side_reg[lei_pkg::ST_XI].p3),
        .xi   (side_reg[lei_pkg::ST_XI].xi),
        .coef (side_reg[lei_pkg::ST_XI].p2),
        .res  (h1u_res)
    );

    lei_horner_step u_h1d (
        .clk  (clk),
        .en   (en),
        .acc  (side_reg[lei_pkg::ST_XI].p3x3),
        .xi   (side_reg[lei_pkg::ST_XI].xi),
        .coef (side_reg[lei_pkg::ST_XI].p2x2),
        .res  (h1d_res)
    );

    lei_horner_step u_h2u (
        .clk  (clk),
        .en   (en),
        .acc  (h1u_res),
        .xi   (side_reg[lei_pkg::ST_H2].xi),
        .coef (side_reg[lei_pkg::ST_H2].p1),
        .res  (h2u_res)
    );

    lei_horner_step u_h2d (
        .clk  (clk),
        .en   (en),
        .acc  (h1d_res),
        .xi   (side_reg[lei_pkg::ST_H2].xi),
        .coef (side_reg[lei_pkg::ST_H2].p1),
        .res  (h2d_res)
    );

    lei_horner_step u_h3u (
        .clk  (clk),
        .en   (en),
        .acc  (h2u_res),
        .xi   (side_reg[lei_pkg::ST_H3].xi),
        .coef (side_reg[lei_pkg::ST_H3].p0),
        .res  (h3u_res)
    );

    assign res_valid   = v_reg[LAST];
    assign value_out   = side_reg[LAST].value;
    assign slope_out   = side_reg[LAST].slope;
    assign bad_element = side_reg[LAST].bad;
    assign saturated   = side_reg[LAST].sat;

endmodule
`default_nettype wire

// File: rtl/core/lei_horner_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lei_horner_step
// one horner step, res = round(acc * xi / 2^16) + coef, three stages:
// split multiply, partial product sum, rounding and coefficient add
// ----------------------------------------------------------------------------
module lei_horner_step (
    input  wire logic                                clk,
    input  wire logic                                en,
    input  wire logic signed [lei_pkg::ACC_W-1:0]    acc,
    input  wire logic signed [lei_pkg::XI_W-1:0]     xi,
    input  wire logic signed [lei_pkg::ACC_W-1:0]    coef,
    output logic signed [lei_pkg::ACC_W-1:0]         res
);

    logic signed [26:0]                 lo_op;
    logic signed [25:0]                 hi_op;
    logic signed [47:0]                 lo_next;
    logic signed [46:0]                 hi_next;
    logic signed [47:0]                 lo_reg;
    logic signed [46:0]                 hi_reg;
    logic signed [lei_pkg::ACC_W-1:0]   coef_a_reg;
    logic [72:0]                        prod_next;
    logic [72:0]                        prod_reg;
    logic signed [lei_pkg::ACC_W-1:0]   coef_b_reg;
    logic [72:0]                        rnd;
    logic signed [lei_pkg::ACC_W-1:0]   res_next;
    logic signed [lei_pkg::ACC_W-1:0]   res_reg;

    assign lo_op   = {1'b0, acc[25:0]};
    assign hi_op   = acc[51:26];
    assign lo_next = lo_op * xi;
    assign hi_next = hi_op * xi;

    assign prod_next = {hi_reg, 26'd0} + {{25{lo_reg[47]}}, lo_reg};

    // ties away from zero: add half, less one when negative, then floor
    assign rnd      = prod_reg + 73'd32768 - {72'd0, prod_reg[72]};
    assign res_next = $signed(rnd[67:16]) + coef_b_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo_reg     <= lo_next;
            hi_reg     <= hi_next;
            coef_a_reg <= coef;
            prod_reg   <= prod_next;
            coef_b_reg <= coef_a_reg;
            res_reg    <= res_next;
        end
    end

    assign res = res_reg;

endmodule
`default_nettype wire

// File: rtl/core/lei_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lei_checker
// port level checks on the element interpolator, bound to the top level
// ----------------------------------------------------------------------------
module lei_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               req_valid,
    input wire logic               req_stall,
    input wire logic               res_valid,
    input wire logic               res_stall,
    input wire logic signed [31:0] value_out,
    input wire logic signed [31:0] slope_out,
    input wire logic               bad_element,
    input wire logic               saturated
);

    // a held result stays offered
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(value_out) && $stable(slope_out))
        else $error("result changed while stalled");

    // request side only backs up behind a stalled result
    a_req_stall: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> res_valid && res_stall)
        else $error("request stalled without a waiting result");

    // a bad element gives zero results
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && bad_element |-> value_out == 32'sd0 && slope_out == 32'sd0 && !saturated)
        else $error("bad element with non-zero result");

    // free flowing pipeline never stalls requests
    a_free_flow: assert property (@(posedge clk) disable iff (!rst_n)
        !res_stall |-> !req_stall)
        else $error("request stalled with open result side");

endmodule

bind lagrange_element_interpolator lei_checker u_lei_checker (.*);
`default_nettype wire
